/* rtl/bounded_byte_stream_fifo_top_macros.svh */
// assertion macros for the bounded byte fifo checker
// no dependencies; included by the checker file only
`ifndef BOUNDED_BYTE_STREAM_FIFO_TOP_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_TOP_MACROS_SVH

// generic clocked property with reset disable
`define BBF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// a stalled transaction keeps valid high and its payload unchanged
`define BBF_ASSERT_HOLD(label, clk, rstn, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

/* rtl/bbf_pkg.sv */
// shared types, codes and widths for the bounded byte fifo
// no dependencies; used by every other rtl file except the macro header
package bbf_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int MAX_LEN_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CAP_W  = 11;
    localparam int TOT_W  = 32;

    // entries in the queue between front and back
    localparam int QDEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_PEEK,
        OP_POP,
        OP_CLOSE,
        OP_BAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
        logic              len_zero;
        logic              len_over;
    } op_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } bk_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last;
        logic              accepted;
        logic [CAP_W-1:0]  occupancy;
        logic [CAP_W-1:0]  room_left;
        logic [TOT_W-1:0]  total_written;
        logic [TOT_W-1:0]  total_read;
        logic              input_closed;
        logic              end_of_stream;
    } res_t;

endpackage

/* rtl/bbf_if.sv */
// command and result channel interfaces, valid/ready handshake
// depends on bbf_pkg for field widths
interface bbf_cmd_if import bbf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output cmd, output data_byte, output length, input ready);
    modport sink   (input valid, input cmd, input data_byte, input length, output ready);
endinterface

interface bbf_res_if import bbf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CAP_W-1:0]  occupancy;
    logic [CAP_W-1:0]  room_left;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
    logic              input_closed;
    logic              end_of_stream;

    modport source (
        output valid, output out_byte, output byte_valid, output last, output accepted,
        output occupancy, output room_left, output total_written, output total_read,
        output input_closed, output end_of_stream, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input last, input accepted,
        input occupancy, input room_left, input total_written, input total_read,
        input input_closed, input end_of_stream, output ready
    );
endinterface

/* rtl/bbf_front.sv */
// front end: accepts command transactions, decodes them and queues them
// depends on bbf_pkg and bbf_cmd_if
module bbf_front import bbf_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bbf_cmd_if.sink    cmd_ch,
    output logic       op_valid,
    output op_t        op,
    input  logic       op_pop
);

    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    op_t               q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    op_t               op_in;
    logic              push;

    // decode
    always_comb
    begin
        op_in.data     = cmd_ch.data_byte;
        op_in.length   = cmd_ch.length;
        op_in.len_zero = (cmd_ch.length == '0);
        op_in.len_over = (int'(cmd_ch.length) > MAX_LEN);
        unique case (cmd_ch.cmd)
            CMD_WRITE: op_in.kind = OP_WRITE;
            CMD_READ:  op_in.kind = OP_READ;
            CMD_PEEK:  op_in.kind = OP_PEEK;
            CMD_POP:   op_in.kind = OP_POP;
            CMD_CLOSE: op_in.kind = OP_CLOSE;
            default:   op_in.kind = OP_BAD;
        endcase
    end

    assign cmd_ch.ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push         = cmd_ch.valid && cmd_ch.ready;
    assign op_valid     = (cnt_reg != '0);
    assign op           = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (op_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, op_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

/* rtl/bbf_back.sv */
// back end: byte store, pointers, totals and result sequencer
// depends on bbf_pkg and bbf_res_if
module bbf_back import bbf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity,
    input  logic             op_valid,
    input  op_t              op,
    output logic             op_pop,
    bbf_res_if.source        res_ch
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int AW    = SW + 1;

    logic [BYTE_W-1:0] mem [DEPTH];

    bk_state_t         state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [TOT_W-1:0]  wtot_reg, wtot_next;
    logic [TOT_W-1:0]  rtot_reg, rtot_next;
    logic              closed_reg, closed_next;
    logic [PTR_W-1:0]  sptr_reg, sptr_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [BYTE_W-1:0] rdata_reg;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              out_free;
    logic              load;
    logic              mem_we;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] r_byte;
    logic              r_bvalid;
    logic              r_last;
    logic              r_acc;

    logic [SW-1:0]     fill_x;
    logic [SW-1:0]     cap_eff;
    logic [SW-1:0]     fill_nx;
    logic [AW-1:0]     hsum;
    logic [PTR_W-1:0]  head_adv;
    logic [PTR_W-1:0]  sptr_inc;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  tail_inc;
    logic [TOT_W:0]    rsum;

    assign out_free = !res_valid_reg || res_ch.ready;
    assign fill_x   = SW'(fill_reg);
    assign cap_eff  = (SW'(capacity) < SW'(DEPTH)) ? SW'(capacity) : SW'(DEPTH);

    // head moves by length modulo depth; length never exceeds the fill
    assign hsum     = AW'(head_reg) + AW'(op.length);
    assign head_adv = (hsum >= AW'(DEPTH)) ? PTR_W'(hsum - AW'(DEPTH)) : PTR_W'(hsum);
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign sptr_inc = (sptr_reg == PTR_W'(DEPTH - 1)) ? '0 : sptr_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign rsum     = {1'b0, rtot_reg} + (TOT_W + 1)'(op.length);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        wtot_next   = wtot_reg;
        rtot_next   = rtot_reg;
        closed_next = closed_reg;
        sptr_next   = sptr_reg;
        remain_next = remain_reg;
        op_pop      = 1'b0;
        load        = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = sptr_reg;
        r_byte      = '0;
        r_bvalid    = 1'b0;
        r_last      = 1'b1;
        r_acc       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop = 1'b1;
                    unique case (op.kind) inside
                        OP_WRITE:
                        begin
                            load = 1'b1;
                            if (fill_x < cap_eff)
                            begin
                                mem_we    = 1'b1;
                                tail_next = tail_inc;
                                fill_next = fill_reg + 1'b1;
                                wtot_next = (wtot_reg == '1) ? wtot_reg : wtot_reg + 1'b1;
                                r_acc     = 1'b1;
                            end
                        end
                        OP_READ, OP_PEEK, OP_POP:
                        begin
                            if (!op.len_over && (SW'(op.length) <= fill_x))
                            begin
                                r_acc = 1'b1;
                                if (op.kind != OP_PEEK)
                                begin
                                    head_next = head_adv;
                                    fill_next = fill_reg - CNT_W'(op.length);
                                    rtot_next = rsum[TOT_W] ? '1 : rsum[TOT_W-1:0];
                                end
                                if (op.kind == OP_POP || op.len_zero)
                                begin
                                    load = 1'b1;
                                end
                                else
                                begin
                                    // first byte fetched from the old head
                                    rd_en       = 1'b1;
                                    rd_addr     = head_reg;
                                    sptr_next   = head_inc;
                                    remain_next = op.length;
                                    state_next  = ST_EMIT;
                                end
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            closed_next = 1'b1;
                            r_acc       = 1'b1;
                            load        = 1'b1;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    r_byte      = rdata_reg;
                    r_bvalid    = 1'b1;
                    r_acc       = 1'b1;
                    r_last      = (remain_reg == LEN_W'(1));
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg != LEN_W'(1))
                    begin
                        // fetch the following byte while this one goes out
                        rd_en     = 1'b1;
                        sptr_next = sptr_inc;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // status fields always show the state after the command
    assign fill_nx = SW'(fill_next);

    always_comb
    begin
        res_next.out_byte      = r_byte;
        res_next.byte_valid    = r_bvalid;
        res_next.last          = r_last;
        res_next.accepted      = r_acc;
        res_next.occupancy     = CAP_W'(fill_nx);
        res_next.room_left     = (cap_eff > fill_nx) ? CAP_W'(cap_eff - fill_nx) : '0;
        res_next.total_written = wtot_next;
        res_next.total_read    = rtot_next;
        res_next.input_closed  = closed_next;
        res_next.end_of_stream = closed_next && (fill_next == '0);
        res_valid_next         = load ? 1'b1 : (res_valid_reg && !res_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            wtot_reg      <= '0;
            rtot_reg      <= '0;
            closed_reg    <= 1'b0;
            sptr_reg      <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            wtot_reg      <= wtot_next;
            rtot_reg      <= rtot_next;
            closed_reg    <= closed_next;
            sptr_reg      <= sptr_next;
            remain_reg    <= remain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= op.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign res_ch.valid         = res_valid_reg;
    assign res_ch.out_byte      = res_reg.out_byte;
    assign res_ch.byte_valid    = res_reg.byte_valid;
    assign res_ch.last          = res_reg.last;
    assign res_ch.accepted      = res_reg.accepted;
    assign res_ch.occupancy     = res_reg.occupancy;
    assign res_ch.room_left     = res_reg.room_left;
    assign res_ch.total_written = res_reg.total_written;
    assign res_ch.total_read    = res_reg.total_read;
    assign res_ch.input_closed  = res_reg.input_closed;
    assign res_ch.end_of_stream = res_reg.end_of_stream;

endmodule

/* rtl/bounded_byte_stream_fifo_top.sv */
// top level of the bounded byte fifo: capacity register, front end, back end
// depends on bbf_pkg, bbf_if, bbf_front and bbf_back
//
//   channel   dir   handshake      contents
//   cmd_ch    in    valid/ready    cmd, data_byte, length
//   res_ch    out   valid/ready    out_byte, byte_valid, last, accepted, status
//   cfg       in    cfg_wr_en      cfg_wr_data -> capacity
//
// write, pop, end input, refused and zero length commands each give a single result.
// an accepted read or peek of n bytes starts by fetching the first byte, then sends one
// byte per cycle unless results stall, paced by the registered read port of the byte store.
// a two-entry queue between front and back buffers up to two commands while results stall.
// reset clears pointers, counts, totals and flags; the byte store itself is not cleared.
module bounded_byte_stream_fifo_top import bbf_pkg::*; #(
    parameter int DEPTH   = DEPTH_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    bbf_cmd_if.sink          cmd_ch,
    bbf_res_if.source        res_ch,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic             op_valid;
    op_t              op;
    logic             op_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    bbf_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_ch   (cmd_ch),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    bbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .res_ch   (res_ch)
    );

endmodule

/* rtl/bbf_checker.sv */
// port-level checks on the result channel of the bounded byte fifo
// depends on bbf_pkg and the assertion macro header; bound to the top level
`include "bounded_byte_stream_fifo_top_macros.svh"

module bbf_checker import bbf_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic              byte_valid,
    input logic              last,
    input logic              accepted,
    input logic [CAP_W-1:0]  occupancy,
    input logic              input_closed,
    input logic              end_of_stream
);

    logic                                seen_closed_reg;
    logic [BYTE_W+CAP_W+5-1:0]           res_bits;

    assign res_bits = {out_byte, byte_valid, last, accepted, occupancy,
                       input_closed, end_of_stream};

    // input closed once delivered must stay closed in later transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_closed_reg <= 1'b0;
        end
        else if (res_valid && res_ready && input_closed)
        begin
            seen_closed_reg <= 1'b1;
        end
    end

    `BBF_ASSERT_HOLD(a_res_hold, clk, rst_n, res_valid, res_ready, res_bits, "result changed while stalled")
    `BBF_ASSERT(a_eos, clk, rst_n, res_valid |-> (end_of_stream == (input_closed && occupancy == '0)), "end of stream inconsistent")
    `BBF_ASSERT(a_status, clk, rst_n, (res_valid && !byte_valid) |-> (last && out_byte == '0), "status result malformed")
    `BBF_ASSERT(a_byte_acc, clk, rst_n, (res_valid && byte_valid) |-> accepted, "byte from refused command")
    `BBF_ASSERT(a_closed, clk, rst_n, (res_valid && seen_closed_reg) |-> input_closed, "input reopened")

endmodule

bind bounded_byte_stream_fifo_top bbf_checker u_bbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .out_byte      (res_ch.out_byte),
    .byte_valid    (res_ch.byte_valid),
    .last          (res_ch.last),
    .accepted      (res_ch.accepted),
    .occupancy     (res_ch.occupancy),
    .input_closed  (res_ch.input_closed),
    .end_of_stream (res_ch.end_of_stream)
);

/* sim/tb_bounded_byte_stream_fifo_top.sv */
// self-checking testbench for bounded_byte_stream_fifo_top: a local byte fifo predictor
// feeds a queue of expected results that each result transaction is compared against
// depends on bbf_pkg and the bbf_cmd_if / bbf_res_if interfaces
module tb_bounded_byte_stream_fifo_top;
    import bbf_pkg::*;

    localparam int FIFO_DEPTH     = DEPTH_DEF;
    localparam int MAX_LEN        = MAX_LEN_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int FINAL_SETTLE   = 80;
    localparam int MAX_PRINTED    = 40;
    localparam int FULL_CAP       = 8;

    // command codes the block treats as undefined
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    bbf_cmd_if cmd_ch ();
    bbf_res_if res_ch ();

    bounded_byte_stream_fifo_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ch      (cmd_ch),
        .res_ch      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state
    logic [BYTE_W-1:0] model_store [FIFO_DEPTH];
    int unsigned       model_head     = 0;
    int unsigned       model_tail     = 0;
    int unsigned       model_fill     = 0;
    logic [TOT_W-1:0]  model_written  = '0;
    logic [TOT_W-1:0]  model_read     = '0;
    bit                model_closed   = 1'b0;
    int unsigned       model_capacity = CAP_RESET;

    res_t expected_results [$];

    int mismatch_count      = 0;
    int results_seen        = 0;
    int cmd_idle_pct        = 15;
    int res_idle_pct        = 15;
    int res_holdoff_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic res_t fifo_status(input logic [BYTE_W-1:0] b, input bit bv,
                                         input bit lst, input bit acc);
        res_t        r;
        int unsigned cap;
        cap = (model_capacity < FIFO_DEPTH) ? model_capacity : FIFO_DEPTH;
        r.out_byte      = b;
        r.byte_valid    = bv;
        r.last          = lst;
        r.accepted      = acc;
        r.occupancy     = CAP_W'(model_fill);
        r.room_left     = (cap > model_fill) ? CAP_W'(cap - model_fill) : '0;
        r.total_written = model_written;
        r.total_read    = model_read;
        r.input_closed  = model_closed;
        r.end_of_stream = model_closed && (model_fill == 0);
        return r;
    endfunction

    function automatic void queue_expected(input res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_fifo_results(input logic [CMD_W-1:0] c,
                                                 input logic [BYTE_W-1:0] d,
                                                 input logic [LEN_W-1:0] l);
        logic [BYTE_W-1:0] taken [MAX_LEN];
        logic [TOT_W:0]    sum;
        int unsigned       cap;
        int unsigned       n;
        int                i;
        cap = (model_capacity < FIFO_DEPTH) ? model_capacity : FIFO_DEPTH;
        n = l;
        case (c) inside
            CMD_WRITE:
            begin
                if (model_fill < cap)
                begin
                    model_store[model_tail] = d;
                    model_tail = (model_tail + 1) % FIFO_DEPTH;
                    model_fill++;
                    if (model_written != '1)
                        model_written++;
                    queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b1));
                end
                else
                    queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b0));
            end
            CMD_READ, CMD_PEEK, CMD_POP:
            begin
                if (n > MAX_LEN || n > model_fill)
                    queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b0));
                else
                begin
                    for (i = 0; i < n; i++)
                        taken[i] = model_store[(model_head + i) % FIFO_DEPTH];
                    if (c != CMD_PEEK)
                    begin
                        model_head = (model_head + n) % FIFO_DEPTH;
                        model_fill -= n;
                        sum = {1'b0, model_read} + n;
                        model_read = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
                    end
                    if (c == CMD_POP || n == 0)
                        queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b1));
                    else
                        for (i = 0; i < n; i++)
                            queue_expected(fifo_status(taken[i], 1'b1, (i == n - 1), 1'b1));
                end
            end
            CMD_CLOSE:
            begin
                model_closed = 1'b1;
                queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b1));
            end
            default:
                queue_expected(fifo_status('0, 1'b0, 1'b1, 1'b0));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
                                   input logic [TOT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch: result %0d at %0t: %s got %0h expected %0h",
                     results_seen, $realtime, what, got, want);
    endtask

    // one command transaction; valid stays high afterwards until the next call or a stop
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d,
                            input logic [LEN_W-1:0] l);
        @(negedge clk);
        while (cmd_idle_pct != 0 && $urandom_range(99) < cmd_idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     = 1'b1;
        cmd_ch.cmd       = c;
        cmd_ch.data_byte = d;
        cmd_ch.length    = l;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        predict_fifo_results(c, d, l);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        stop_sending();
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        model_capacity = value;
    endtask

    task automatic send_random_op(input int write_pct);
        int unsigned      roll;
        int unsigned      limit;
        logic [LEN_W-1:0] len;
        logic [CMD_W-1:0] op;
        limit = (model_fill < MAX_LEN) ? model_fill : MAX_LEN;
        // mostly lengths that can be satisfied, some anywhere in the field
        if ($urandom_range(99) < 80)
            len = LEN_W'($urandom_range(limit));
        else
            len = LEN_W'($urandom_range(127));
        roll = $urandom_range(99);
        if (roll < write_pct)
            op = CMD_WRITE;
        else
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                op = CMD_READ;
            else if (roll < 60)
                op = CMD_PEEK;
            else if (roll < 85)
                op = CMD_POP;
            else if (roll < 93)
                op = CMD_CLOSE;
            else
                op = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
        end
        send_cmd(op, BYTE_W'($urandom_range(255)), len);
    endtask

    task automatic test_directed_basics();
        send_cmd(CMD_WRITE, 8'h00, '0);
        send_cmd(CMD_WRITE, 8'hFF, '0);
        send_cmd(CMD_WRITE, 8'h5A, 7'd127);
        send_cmd(CMD_READ, 8'hFF, 7'd0);
        send_cmd(CMD_PEEK, 8'h00, 7'd0);
        send_cmd(CMD_POP, 8'h00, 7'd0);
        send_cmd(CMD_PEEK, 8'h00, 7'd2);
        send_cmd(CMD_READ, 8'h00, 7'd1);
        send_cmd(CMD_POP, 8'h00, 7'd1);
        // more than stored, above the length limit, all length bits set
        send_cmd(CMD_READ, 8'h00, 7'd2);
        send_cmd(CMD_READ, 8'h00, 7'd65);
        send_cmd(CMD_PEEK, 8'h00, 7'd127);
        send_cmd(CMD_RSVD_FIRST, 8'h12, 7'd1);
        send_cmd(CMD_W'(CMD_RSVD_FIRST + 1'b1), 8'h34, 7'd0);
        send_cmd(CMD_RSVD_LAST, 8'hFF, 7'd127);
    endtask

    task automatic test_capacity_limits();
        write_capacity(11'd0);
        send_cmd(CMD_WRITE, 8'h11, '0);
        write_capacity(11'd2);
        send_cmd(CMD_WRITE, 8'h22, '0);
        send_cmd(CMD_WRITE, 8'h33, '0);
        // capacity below occupancy: no room, stored bytes stay
        write_capacity(11'd1);
        send_cmd(CMD_WRITE, 8'h44, '0);
        write_capacity(11'd2047);
        send_cmd(CMD_WRITE, 8'h55, '0);
    endtask

    task automatic test_end_of_input();
        send_cmd(CMD_CLOSE, 8'h00, '0);
        send_cmd(CMD_WRITE, 8'h66, '0);
        send_cmd(CMD_CLOSE, 8'h00, '0);
        send_cmd(CMD_READ, 8'h00, LEN_W'(model_fill));
    endtask

    task automatic test_result_backpressure();
        int i;
        res_holdoff_request = HOLDOFF_CYCLES;
        for (i = 0; i < 20; i++)
            send_cmd(CMD_WRITE, BYTE_W'($urandom_range(255)), '0);
        send_cmd(CMD_PEEK, 8'h00, 7'd8);
        send_cmd(CMD_READ, 8'h00, 7'd8);
        send_cmd(CMD_POP, 8'h00, 7'd12);
    endtask

    task automatic test_full_fifo();
        int unsigned limit;
        write_capacity(CAP_W'(FULL_CAP));
        while (model_fill < FULL_CAP)
            send_cmd(CMD_WRITE, BYTE_W'($urandom_range(255)), '0);
        // full: the byte is dropped
        send_cmd(CMD_WRITE, 8'hA5, '0);
        send_cmd(CMD_READ, 8'h00, LEN_W'(MAX_LEN));
        while (model_fill > 0)
        begin
            limit = (model_fill < MAX_LEN) ? model_fill : MAX_LEN;
            send_cmd(CMD_W'($urandom_range(CMD_POP, CMD_READ)), 8'h00,
                     LEN_W'($urandom_range(limit, 1)));
        end
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [6];
        int               phase;
        int               i;
        int               count;
        int               write_pct;
        caps = '{11'd2047, 11'd16, 11'd1, 11'd0, 11'd1024, 11'd0};
        caps[5] = CAP_W'($urandom_range(2047));
        for (phase = 0; phase < 6; phase++)
        begin
            write_capacity(caps[phase]);
            // one phase runs with neither side idling
            cmd_idle_pct = (phase == 4) ? 0 : 15;
            res_idle_pct = (phase == 4) ? 0 : 15;
            count = (caps[phase] == 0) ? 8 : 25;
            for (i = 0; i < count; i++)
            begin
                write_pct = (model_fill < 8) ? 70 : 45;
                send_random_op(write_pct);
            end
        end
        cmd_idle_pct = 15;
        res_idle_pct = 15;
    endtask

    // result receiver with random stalls and a long hold-off on request
    initial
    begin : drive_res_ready
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else if (res_holdoff_request > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left = res_holdoff_request - 1;
                res_holdoff_request = 0;
            end
            else
                res_ch.ready = ($urandom_range(99) >= res_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", res_ch.out_byte, '0);
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (res_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", res_ch.out_byte, want.out_byte);
                if (res_ch.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", res_ch.byte_valid, want.byte_valid);
                if (res_ch.last !== want.last)
                    report_mismatch("last", res_ch.last, want.last);
                if (res_ch.accepted !== want.accepted)
                    report_mismatch("accepted", res_ch.accepted, want.accepted);
                if (res_ch.occupancy !== want.occupancy)
                    report_mismatch("occupancy", res_ch.occupancy, want.occupancy);
                if (res_ch.room_left !== want.room_left)
                    report_mismatch("room_left", res_ch.room_left, want.room_left);
                if (res_ch.total_written !== want.total_written)
                    report_mismatch("total_written", res_ch.total_written,
                                    want.total_written);
                if (res_ch.total_read !== want.total_read)
                    report_mismatch("total_read", res_ch.total_read, want.total_read);
                if (res_ch.input_closed !== want.input_closed)
                    report_mismatch("input_closed", res_ch.input_closed, want.input_closed);
                if (res_ch.end_of_stream !== want.end_of_stream)
                    report_mismatch("end_of_stream", res_ch.end_of_stream,
                                    want.end_of_stream);
            end
        end
    end

    // ends the run once nothing has moved on either channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd       = CMD_WRITE;
        cmd_ch.data_byte = '0;
        cmd_ch.length    = '0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed_basics();
        test_capacity_limits();
        test_end_of_input();
        test_result_backpressure();
        test_full_fifo();
        test_random_traffic();

        stop_sending();
        wait_drained();
        repeat (FINAL_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
